// File: src/tri3_pkg.sv
package tri3_pkg;

  localparam int NUM_REGS = 7;
  localparam int REG_A1X  = 0;
  localparam int REG_A1Y  = 1;
  localparam int REG_A2X  = 2;
  localparam int REG_A2Y  = 3;
  localparam int REG_A3X  = 4;
  localparam int REG_A3Y  = 5;
  localparam int REG_MAXD = 6;

  // Register reset values in whole centimetres.
  localparam int RESET_CM [NUM_REGS] = '{30, 60, 45, 40, 30, 10, 60};

  // Equation e uses anchors PAIR_P[e] and PAIR_Q[e]; slot s solves EQ_U[s] with EQ_V[s].
  localparam int PAIR_P [3] = '{0, 1, 0};
  localparam int PAIR_Q [3] = '{1, 2, 2};
  localparam int EQ_U   [3] = '{0, 1, 0};
  localparam int EQ_V   [3] = '{1, 2, 2};

  localparam int AB_W   = 18;
  localparam int R2_W   = 33;
  localparam int KC_W   = 34;
  localparam int C_W    = 35;
  localparam int PR_W   = 53;
  localparam int NX_W   = 54;
  localparam int DET_W  = 37;
  localparam int DIV_NW = 56;
  localparam int DIV_DW = DET_W + 1;
  localparam int SUM_W  = DIV_NW + 3;
  localparam int AVG_NW = SUM_W + 1;
  localparam int AVG_DW = 3;

  typedef struct packed {
    logic [15:0] dist_one;
    logic [15:0] dist_two;
    logic [15:0] dist_three;
  } in_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic               pos_valid;
    logic [1:0]         used_count;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic [2:0][15:0] ax;
    logic [2:0][15:0] ay;
    logic [15:0]      max_d;
  } cfg_t;

  typedef struct packed {
    logic                    valid;
    logic [2:0]              keep;
    logic [5:0]              neg;
    logic [5:0][DIV_NW-1:0]  num;
    logic [2:0][DIV_DW-1:0]  den;
  } front_t;

endpackage

// File: src/trilateration_three_anchor_top.sv
// Channel   Valid      Stall      Payload    Beat
// input     in_valid   in_stall   in_data    three distances
// output    out_valid  out_stall  out_data   one position
// A new beat is taken every cycle unless the output stalls; a beat passes through
// the two bit-per-stage dividers (56 and 60 stages) and ten other stages.
// Reset restores the anchor and range registers and empties every stage.
// A stalled output holds the whole pipeline, and in_stall follows it in the same cycle.
module trilateration_three_anchor_top #(
  parameter int FRAC_BITS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  tri3_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output tri3_pkg::out_t   out_data,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [15:0]      cfg_data
);

  localparam logic signed [tri3_pkg::AVG_NW:0] POS_MAX = 32767;
  localparam logic signed [tri3_pkg::AVG_NW:0] POS_MIN = -32768;

  logic [15:0]       cfg_regs [tri3_pkg::NUM_REGS];
  tri3_pkg::cfg_t    cfg;
  tri3_pkg::front_t  front;
  logic              en;

  logic [5:0]                     qv;
  logic [tri3_pkg::DIV_NW-1:0]    quo  [6];
  logic [1:0]                     qtag [6];

  logic                                 p1v, p2v, p3v;
  logic signed [tri3_pkg::DIV_NW:0]     qs [6];
  logic [1:0]                           cnt1, cnt2, cnt3;
  logic signed [tri3_pkg::SUM_W-1:0]    sumx, sumy;
  logic [tri3_pkg::SUM_W-1:0]           mx, my;
  logic [tri3_pkg::AVG_NW-1:0]          numx, numy;
  logic [tri3_pkg::AVG_DW-1:0]          den2;
  logic                                 negx, negy;

  logic [1:0]                     av;
  logic [tri3_pkg::AVG_NW-1:0]    aq   [2];
  logic [2:0]                     atag [2];
  logic signed [tri3_pkg::AVG_NW:0] rx, ry;
  logic                           hix, lox, hiy, loy;
  tri3_pkg::out_t                 res;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tri3_pkg::NUM_REGS; i++) begin
        cfg_regs[i] <= 16'(tri3_pkg::RESET_CM[i] << FRAC_BITS);
      end
    end else if (cfg_we && (cfg_index < 3'(tri3_pkg::NUM_REGS))) begin
      cfg_regs[cfg_index] <= cfg_data;
    end
  end

  assign cfg.ax[0] = cfg_regs[tri3_pkg::REG_A1X];
  assign cfg.ay[0] = cfg_regs[tri3_pkg::REG_A1Y];
  assign cfg.ax[1] = cfg_regs[tri3_pkg::REG_A2X];
  assign cfg.ay[1] = cfg_regs[tri3_pkg::REG_A2Y];
  assign cfg.ax[2] = cfg_regs[tri3_pkg::REG_A3X];
  assign cfg.ay[2] = cfg_regs[tri3_pkg::REG_A3Y];
  assign cfg.max_d = cfg_regs[tri3_pkg::REG_MAXD];

  tri3_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .in_data  (in_data),
    .cfg      (cfg),
    .front    (front)
  );

  for (genvar j = 0; j < 6; j++) begin : g_slot_div
    tri3_div #(
      .NW (tri3_pkg::DIV_NW),
      .DW (tri3_pkg::DIV_DW),
      .TW (2)
    ) u_div (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .vin     (front.valid),
      .num     (front.num[j]),
      .den     (front.den[j/2]),
      .tag_in  ({front.keep[j/2], front.neg[j]}),
      .vout    (qv[j]),
      .quo     (quo[j]),
      .tag_out (qtag[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1v <= 1'b0;
      p2v <= 1'b0;
      p3v <= 1'b0;
    end else if (en) begin
      p1v <= &qv;
      p2v <= p1v;
      p3v <= p2v;
    end
  end

  always_comb begin
    mx   = sumx[tri3_pkg::SUM_W-1] ? -sumx : sumx;
    my   = sumy[tri3_pkg::SUM_W-1] ? -sumy : sumy;
    numx = {mx, 1'b0} + tri3_pkg::AVG_NW'(cnt2);
    numy = {my, 1'b0} + tri3_pkg::AVG_NW'(cnt2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        if (!qtag[j][1]) begin
          qs[j] <= '0;
        end else if (qtag[j][0]) begin
          qs[j] <= -$signed({1'b0, quo[j]});
        end else begin
          qs[j] <= $signed({1'b0, quo[j]});
        end
      end
      cnt1 <= {1'b0, qtag[0][1]} + {1'b0, qtag[2][1]} + {1'b0, qtag[4][1]};
      sumx <= qs[0] + qs[2] + qs[4];
      sumy <= qs[1] + qs[3] + qs[5];
      cnt2 <= cnt1;
      negx <= sumx[tri3_pkg::SUM_W-1];
      negy <= sumy[tri3_pkg::SUM_W-1];
      cnt3 <= cnt2;
      den2 <= {cnt2, 1'b0};
    end
  end

  logic [tri3_pkg::AVG_NW-1:0] numx3, numy3;

  always_ff @(posedge clk) begin
    if (en) begin
      numx3 <= numx;
      numy3 <= numy;
    end
  end

  tri3_div #(
    .NW (tri3_pkg::AVG_NW),
    .DW (tri3_pkg::AVG_DW),
    .TW (3)
  ) u_avg_x (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vin     (p3v),
    .num     (numx3),
    .den     (den2),
    .tag_in  ({cnt3, negx}),
    .vout    (av[0]),
    .quo     (aq[0]),
    .tag_out (atag[0])
  );

  tri3_div #(
    .NW (tri3_pkg::AVG_NW),
    .DW (tri3_pkg::AVG_DW),
    .TW (3)
  ) u_avg_y (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vin     (p3v),
    .num     (numy3),
    .den     (den2),
    .tag_in  ({cnt3, negy}),
    .vout    (av[1]),
    .quo     (aq[1]),
    .tag_out (atag[1])
  );

  always_comb begin
    rx  = atag[0][0] ? -$signed({1'b0, aq[0]}) : $signed({1'b0, aq[0]});
    ry  = atag[1][0] ? -$signed({1'b0, aq[1]}) : $signed({1'b0, aq[1]});
    hix = rx > POS_MAX;
    lox = rx < POS_MIN;
    hiy = ry > POS_MAX;
    loy = ry < POS_MIN;
    res = '0;
    if (atag[0][2:1] != 2'd0) begin
      res.pos_x      = hix ? 16'sh7fff : (lox ? 16'sh8000 : rx[15:0]);
      res.pos_y      = hiy ? 16'sh7fff : (loy ? 16'sh8000 : ry[15:0]);
      res.pos_valid  = 1'b1;
      res.used_count = atag[0][2:1];
      res.saturated  = hix || lox || hiy || loy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= &av;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= res;
    end
  end

endmodule

// File: src/tri3_div.sv
module tri3_div #(
  parameter int NW = 56,
  parameter int DW = 38,
  parameter int TW = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vin,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag_in,
  output logic          vout,
  output logic [NW-1:0] quo,
  output logic [TW-1:0] tag_out
);

  logic          v   [NW+1];
  logic [DW-1:0] rem [NW+1];
  logic [NW-1:0] nq  [NW+1];
  logic [DW-1:0] dd  [NW+1];
  logic [TW-1:0] tg  [NW+1];

  assign v[0]   = vin;
  assign rem[0] = '0;
  assign nq[0]  = num;
  assign dd[0]  = den;
  assign tg[0]  = tag_in;

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW:0] t;
    logic [DW:0] diff;
    logic        ge;

    assign t    = {rem[k], nq[k][NW-1]};
    assign ge   = t >= {1'b0, dd[k]};
    assign diff = t - {1'b0, dd[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? diff[DW-1:0] : t[DW-1:0];
        nq[k+1]  <= {nq[k][NW-2:0], ge};
        dd[k+1]  <= dd[k];
        tg[k+1]  <= tg[k];
      end
    end
  end

  assign vout    = v[NW];
  assign quo     = nq[NW];
  assign tag_out = tg[NW];

endmodule

// File: src/tri3_front.sv
module tri3_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  tri3_pkg::in_t     in_data,
  input  tri3_pkg::cfg_t    cfg,
  output tri3_pkg::front_t  front
);

  logic signed [15:0] axs [3];
  logic signed [15:0] ays [3];
  logic signed [31:0] sqx [3];
  logic signed [31:0] sqy [3];
  logic signed [16:0] dxa [3];
  logic signed [16:0] dya [3];

  logic signed [tri3_pkg::AB_W-1:0]  a_c  [3];
  logic signed [tri3_pkg::AB_W-1:0]  b_c  [3];
  logic signed [tri3_pkg::R2_W-1:0]  r2   [3];
  logic signed [tri3_pkg::KC_W-1:0]  kc   [3];
  logic signed [tri3_pkg::DET_W-1:0] pab  [3];
  logic signed [tri3_pkg::DET_W-1:0] pba  [3];
  logic signed [tri3_pkg::DET_W-1:0] det  [3];

  logic v1, v2, v3, v4, v5;
  logic [15:0]                        d1   [3];
  logic [31:0]                        dsq  [3];
  logic [2:0]                         ok2, ok3, ok4;
  logic signed [tri3_pkg::C_W-1:0]    c3   [3];
  logic signed [tri3_pkg::PR_W-1:0]   pcx1 [3];
  logic signed [tri3_pkg::PR_W-1:0]   pcx2 [3];
  logic signed [tri3_pkg::PR_W-1:0]   pcy1 [3];
  logic signed [tri3_pkg::PR_W-1:0]   pcy2 [3];
  logic signed [tri3_pkg::NX_W-1:0]   nx5  [3];
  logic signed [tri3_pkg::NX_W-1:0]   ny5  [3];
  logic signed [tri3_pkg::DET_W-1:0]  det5 [3];
  logic [2:0]                         keep5;

  logic [tri3_pkg::NX_W-1:0]  mnx [3];
  logic [tri3_pkg::NX_W-1:0]  mny [3];
  logic [tri3_pkg::DET_W-1:0] md  [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      axs[k] = $signed(cfg.ax[k]);
      ays[k] = $signed(cfg.ay[k]);
      sqx[k] = axs[k] * axs[k];
      sqy[k] = ays[k] * ays[k];
    end
    for (int e = 0; e < 3; e++) begin
      dxa[e] = 17'(axs[tri3_pkg::PAIR_Q[e]]) - 17'(axs[tri3_pkg::PAIR_P[e]]);
      dya[e] = 17'(ays[tri3_pkg::PAIR_Q[e]]) - 17'(ays[tri3_pkg::PAIR_P[e]]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      a_c[k] <= {dxa[k], 1'b0};
      b_c[k] <= {dya[k], 1'b0};
      r2[k]  <= sqx[k] + sqy[k];
      kc[k]  <= r2[tri3_pkg::PAIR_Q[k]] - r2[tri3_pkg::PAIR_P[k]];
      pab[k] <= a_c[tri3_pkg::EQ_U[k]] * b_c[tri3_pkg::EQ_V[k]];
      pba[k] <= b_c[tri3_pkg::EQ_U[k]] * a_c[tri3_pkg::EQ_V[k]];
      det[k] <= pab[k] - pba[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      front.valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      front.valid <= v5;
    end
  end

  always_comb begin
    for (int s = 0; s < 3; s++) begin
      mnx[s] = nx5[s][tri3_pkg::NX_W-1] ? -nx5[s] : nx5[s];
      mny[s] = ny5[s][tri3_pkg::NX_W-1] ? -ny5[s] : ny5[s];
      md[s]  = det5[s][tri3_pkg::DET_W-1] ? -det5[s] : det5[s];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1[0] <= in_data.dist_one;
      d1[1] <= in_data.dist_two;
      d1[2] <= in_data.dist_three;
      for (int k = 0; k < 3; k++) begin
        dsq[k] <= d1[k] * d1[k];
        ok2[k] <= (d1[k] != 16'd0) && (d1[k] < cfg.max_d);
        c3[k]  <= $signed({1'b0, dsq[tri3_pkg::PAIR_P[k]]})
                - $signed({1'b0, dsq[tri3_pkg::PAIR_Q[k]]}) + kc[k];
      end
      ok3 <= ok2;
      ok4 <= ok3;
      for (int s = 0; s < 3; s++) begin
        pcx1[s] <= c3[tri3_pkg::EQ_U[s]] * b_c[tri3_pkg::EQ_V[s]];
        pcx2[s] <= b_c[tri3_pkg::EQ_U[s]] * c3[tri3_pkg::EQ_V[s]];
        pcy1[s] <= a_c[tri3_pkg::EQ_U[s]] * c3[tri3_pkg::EQ_V[s]];
        pcy2[s] <= c3[tri3_pkg::EQ_U[s]] * a_c[tri3_pkg::EQ_V[s]];
        nx5[s]   <= pcx1[s] - pcx2[s];
        ny5[s]   <= pcy1[s] - pcy2[s];
        det5[s]  <= det[s];
        keep5[s] <= ok4[s] && (det[s] != '0);
        front.num[2*s]   <= tri3_pkg::DIV_NW'({mnx[s], 1'b0})
                          + tri3_pkg::DIV_NW'(md[s]);
        front.num[2*s+1] <= tri3_pkg::DIV_NW'({mny[s], 1'b0})
                          + tri3_pkg::DIV_NW'(md[s]);
        front.den[s]     <= {md[s], 1'b0};
        front.neg[2*s]   <= nx5[s][tri3_pkg::NX_W-1] ^ det5[s][tri3_pkg::DET_W-1];
        front.neg[2*s+1] <= ny5[s][tri3_pkg::NX_W-1] ^ det5[s][tri3_pkg::DET_W-1];
      end
      front.keep <= keep5;
    end
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int LATENCY = 126;

  typedef enum logic [2:0] {
    IDX_A1X = 3'd0, IDX_A1Y = 3'd1, IDX_A2X = 3'd2, IDX_A2Y = 3'd3,
    IDX_A3X = 3'd4, IDX_A3Y = 3'd5, IDX_MAXD = 3'd6, IDX_NONE = 3'd7
  } reg_idx_e;

  typedef struct {
    logic [15:0]    d1;
    logic [15:0]    d2;
    logic [15:0]    d3;
    bit             typed;
    tri3_pkg::out_t res;
  } row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  tri3_pkg::in_t in_data;
  logic out_valid;
  logic out_stall;
  tri3_pkg::out_t out_data;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;

  logic [15:0] anchor_reg [tri3_pkg::NUM_REGS];
  tri3_pkg::out_t expected_pos [$];
  int errors;
  bit hold_off;
  bit stim_done;

  trilateration_three_anchor_top DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

  function automatic longint rdiv(longint n, longint d);
    bit ng;
    longint mn;
    longint md;
    ng = (n < 0) != (d < 0);
    mn = (n < 0) ? -n : n;
    md = (d < 0) ? -d : d;
    rdiv = (2 * mn + md) / (2 * md);
    if (ng) rdiv = -rdiv;
  endfunction

  function automatic tri3_pkg::out_t solve_position(logic [15:0] d1, logic [15:0] d2,
                                                    logic [15:0] d3);
    longint ax [3];
    longint ay [3];
    longint dv [3];
    longint a [3];
    longint b [3];
    longint c [3];
    longint det;
    longint nx;
    longint ny;
    longint sx;
    longint sy;
    longint px;
    longint py;
    int cnt;
    int p;
    int q;
    tri3_pkg::out_t r;
    sx = 0;
    sy = 0;
    cnt = 0;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      ax[i] = longint'($signed(anchor_reg[2 * i]));
      ay[i] = longint'($signed(anchor_reg[2 * i + 1]));
    end
    dv[0] = d1;
    dv[1] = d2;
    dv[2] = d3;
    for (int e = 0; e < 3; e++) begin
      p = (e == 1) ? 1 : 0;
      q = (e == 0) ? 1 : 2;
      a[e] = 2 * (ax[q] - ax[p]);
      b[e] = 2 * (ay[q] - ay[p]);
      c[e] = dv[p] * dv[p] - dv[q] * dv[q] - ax[p] * ax[p] + ax[q] * ax[q]
           - ay[p] * ay[p] + ay[q] * ay[q];
    end
    for (int s = 0; s < 3; s++) begin
      p = (s == 1) ? 1 : 0;
      q = (s == 0) ? 1 : 2;
      det = a[p] * b[q] - b[p] * a[q];
      nx = c[p] * b[q] - b[p] * c[q];
      ny = a[p] * c[q] - c[p] * a[q];
      if (dv[s] > 0 && dv[s] < longint'(anchor_reg[IDX_MAXD]) && det != 0) begin
        sx += rdiv(nx, det);
        sy += rdiv(ny, det);
        cnt++;
      end
    end
    if (cnt > 0) begin
      px = rdiv(sx, cnt);
      py = rdiv(sy, cnt);
      if (px > 32767 || px < -32768 || py > 32767 || py < -32768) r.saturated = 1'b1;
      if (px > 32767) px = 32767;
      if (px < -32768) px = -32768;
      if (py > 32767) py = 32767;
      if (py < -32768) py = -32768;
      r.pos_x = px[15:0];
      r.pos_y = py[15:0];
      r.pos_valid = 1'b1;
      r.used_count = cnt[1:0];
    end
    return r;
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx != IDX_NONE) anchor_reg[idx] = val;
  endtask

  task automatic drain;
    while (expected_pos.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic send_triple(logic [15:0] d1, logic [15:0] d2, logic [15:0] d3,
                             bit typed, tri3_pkg::out_t res);
    tri3_pkg::out_t pred;
    pred = solve_position(d1, d2, d3);
    if (typed && pred !== res) begin
      $display("%0t: table row disagrees, expected %h predicted %h", $time, res, pred);
      errors++;
    end
    in_valid <= 1'b1;
    in_data <= '{dist_one: d1, dist_two: d2, dist_three: d3};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_pos.push_back(typed ? res : pred);
  endtask

  task automatic gap;
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] rand_dist(logic [15:0] maxd);
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return maxd;
      3: return 16'($urandom);
      default: return (maxd > 1) ? 16'($urandom_range(1, maxd - 1)) : 16'($urandom);
    endcase
  endfunction

  initial begin
    row_t rows [$];
    tri3_pkg::out_t z;
    int n;
    z = '0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    hold_off = 1'b0;
    stim_done = 1'b0;
    for (int i = 0; i < tri3_pkg::NUM_REGS; i++) begin
      anchor_reg[i] = 16'((tri3_pkg::RESET_CM[i] << 8) & 16'hFFFF);
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    rows.push_back('{16'd0, 16'd0, 16'd0, 1'b1, z});
    rows.push_back('{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, z});
    rows.push_back('{16'd15360, 16'd15360, 16'd15360, 1'b1, z});
    rows.push_back('{16'd3840, 16'd3840, 16'd3840, 1'b0, z});
    rows.push_back('{16'd1, 16'd1, 16'd1, 1'b0, z});
    rows.push_back('{16'd15359, 16'd15359, 16'd15359, 1'b0, z});
    rows.push_back('{16'd5000, 16'd0, 16'd0, 1'b0, z});
    rows.push_back('{16'd0, 16'd5000, 16'd0, 1'b0, z});
    rows.push_back('{16'd0, 16'd0, 16'd5000, 1'b0, z});
    rows.push_back('{16'd15359, 16'd1, 16'd15359, 1'b0, z});
    rows.push_back('{16'd1, 16'd15359, 16'd1, 1'b0, z});
    rows.push_back('{16'hAAAA, 16'h5555, 16'h0F0F, 1'b0, z});
    foreach (rows[i]) send_triple(rows[i].d1, rows[i].d2, rows[i].d3, rows[i].typed,
                                  rows[i].res);
    in_valid <= 1'b0;
    drain();

    // Collinear anchors leave every determinant at zero.
    write_reg(IDX_A1X, 16'd0);
    write_reg(IDX_A2X, 16'd0);
    write_reg(IDX_A3X, 16'd0);
    write_reg(IDX_NONE, 16'h1234);
    send_triple(16'd300, 16'd400, 16'd500, 1'b1, z);
    in_valid <= 1'b0;
    drain();

    // Nearly collinear anchors drive the quotient into saturation.
    write_reg(IDX_A1X, 16'd0);
    write_reg(IDX_A1Y, 16'h8000);
    write_reg(IDX_A2X, 16'd1);
    write_reg(IDX_A2Y, 16'd0);
    write_reg(IDX_A3X, 16'd0);
    write_reg(IDX_A3Y, 16'h7FFF);
    write_reg(IDX_MAXD, 16'hFFFF);
    send_triple(16'd100, 16'hFFFE, 16'd7, 1'b0, z);
    send_triple(16'hFFFE, 16'd1, 16'hFFFE, 1'b0, z);
    in_valid <= 1'b0;
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) begin
        write_reg(IDX_A1X, 16'd7680);
        write_reg(IDX_A1Y, 16'd15360);
        write_reg(IDX_A2X, 16'd11520);
        write_reg(IDX_A2Y, 16'd10240);
        write_reg(IDX_A3X, 16'd7680);
        write_reg(IDX_A3Y, 16'd2560);
        write_reg(IDX_MAXD, 16'd15360);
      end else begin
        for (int r = 0; r < 6; r++) begin
          write_reg(reg_idx_e'(r), (ph == 5) ? ((r % 2) ? 16'h7FFF : 16'h8000)
                                             : 16'($urandom));
        end
        write_reg(IDX_MAXD, (ph == 2) ? 16'd0 : (ph == 5) ? 16'hFFFF : 16'($urandom));
      end
      if (ph == 3) hold_off = 1'b1;
      n = 0;
      while (n < 320) begin
        send_triple(rand_dist(anchor_reg[IDX_MAXD]), rand_dist(anchor_reg[IDX_MAXD]),
                    rand_dist(anchor_reg[IDX_MAXD]), 1'b0, z);
        n++;
        gap();
      end
      in_valid <= 1'b0;
      drain();
    end
    stim_done = 1'b1;
    if (errors == 0 && expected_pos.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    int cyc;
    cyc = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_off) begin
        hold_off = 1'b0;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        out_stall <= 1'b0;
      end else if (cyc % 600 < 200) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_pos.size() == 0) begin
        $display("%0t: unexpected beat, expected none actual %h", $time, out_data);
        errors++;
      end else begin
        tri3_pkg::out_t e;
        e = expected_pos.pop_front();
        if (out_data.pos_x !== e.pos_x)
          $display("%0t: pos_x expected %0d actual %0d", $time, e.pos_x, out_data.pos_x);
        if (out_data.pos_y !== e.pos_y)
          $display("%0t: pos_y expected %0d actual %0d", $time, e.pos_y, out_data.pos_y);
        if (out_data.pos_valid !== e.pos_valid)
          $display("%0t: pos_valid expected %0b actual %0b", $time, e.pos_valid,
                   out_data.pos_valid);
        if (out_data.used_count !== e.used_count)
          $display("%0t: used_count expected %0d actual %0d", $time, e.used_count,
                   out_data.used_count);
        if (out_data.saturated !== e.saturated)
          $display("%0t: saturated expected %0b actual %0b", $time, e.saturated,
                   out_data.saturated);
        if (out_data !== e) errors++;
      end
    end
  end

endmodule
